// ===== src/wfc_pkg.sv =====
`default_nettype none

package wfc_pkg;

  localparam int DEF_VALUE_BITS   = 16;
  localparam int DEF_TIME_BITS    = 16;
  localparam int DEF_SINE_ENTRIES = 256;

  localparam int FRAC_BITS = 16;
  localparam int Q_BITS    = FRAC_BITS + 1;
  localparam int DIV_STEPS = Q_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  localparam int ONE_Q16    = 65536;
  localparam int ROUND_HALF = 32768;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  localparam int REG_INDEX_BITS = 3;
  localparam logic [REG_INDEX_BITS-1:0] REG_START  = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_END    = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_CYCLE  = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_MODE   = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_ENABLE = 3'd4;

  localparam int MODE_BITS = 3;
  localparam logic [MODE_BITS-1:0] MODE_TRIANGLE = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_SINE     = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_COSINE   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_SAWTOOTH = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_SQUARE   = 3'd4;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rom_read;
    logic mul;
    logic commit;
  } wfc_cmd_t;

  // Quarter-wave sine point in Q1.16, from a fixed odd-power series in Q30.
  function automatic logic [Q_BITS-1:0] rom_entry(input int idx, input int shift);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    x = (HALF_PI_Q30 * longint'(idx)) >>> shift;
    x2 = x * x / ONE_Q30;
    term = x;
    sum = x;
    term = -(term * x2 / ONE_Q30) / 6;
    sum += term;
    term = -(term * x2 / ONE_Q30) / 20;
    sum += term;
    term = -(term * x2 / ONE_Q30) / 42;
    sum += term;
    term = -(term * x2 / ONE_Q30) / 72;
    sum += term;
    term = -(term * x2 / ONE_Q30) / 110;
    sum += term;
    term = -(term * x2 / ONE_Q30) / 156;
    sum += term;
    r = (sum + 8192) / 16384;
    if (r < 0) begin
      r = 0;
    end
    if (r > ONE_Q16) begin
      r = ONE_Q16;
    end
    return r[Q_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/wfc_ticks_if.sv =====
`default_nettype none

interface wfc_ticks_if import wfc_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] elapsed_ticks;

  modport source (output valid, output elapsed_ticks, input ready);
  modport sink (input valid, input elapsed_ticks, output ready);
endinterface

`default_nettype wire

// ===== src/wfc_wave_if.sv =====
`default_nettype none

interface wfc_wave_if import wfc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] level;
  logic                         rising;
  logic                         wrapped;

  modport source (output valid, output level, output rising, output wrapped, input ready);
  modport sink (input valid, input level, input rising, input wrapped, output ready);
endinterface

`default_nettype wire

// ===== src/wfc_ctrl.sv =====
`default_nettype none

module wfc_ctrl import wfc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     enable,
  output wfc_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ROM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [CNT_BITS-1:0] count;
  logic                out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.load     = in_valid && in_ready;
    cmd.div_step = (state == S_DIV);
    cmd.rom_read = (state == S_ROM);
    cmd.mul      = (state == S_MUL);
    cmd.commit   = (state == S_OUT) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = enable ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (count == CNT_BITS'(DIV_STEPS - 1)) begin
          state_next = S_ROM;
        end
      end
      S_ROM: state_next = S_MUL;
      S_MUL: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.div_step) begin
        count <= count + CNT_BITS'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/wfc_datapath.sv =====
`default_nettype none

module wfc_datapath import wfc_pkg::*; #(
  parameter int VALUE_BITS   = DEF_VALUE_BITS,
  parameter int TIME_BITS    = DEF_TIME_BITS,
  parameter int SINE_ENTRIES = DEF_SINE_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [REG_INDEX_BITS-1:0]         cfg_index,
  input  wire logic [((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS)-1:0] cfg_data,
  input  wire wfc_cmd_t                          cmd,
  input  wire logic [TIME_BITS-1:0]              elapsed_ticks,
  output logic                                   enable,
  output logic signed [VALUE_BITS-1:0]           level,
  output logic                                   rising,
  output logic                                   wrapped
);

  localparam int AB = $clog2(SINE_ENTRIES);
  localparam int PB = AB + 2;
  localparam int IW = AB + 1;
  localparam int SW = VALUE_BITS + 1;
  localparam int PW = SW + Q_BITS + 1;
  localparam int LW = VALUE_BITS + 2;
  localparam logic [IW-1:0] N_IDX = IW'(SINE_ENTRIES);

  logic signed [VALUE_BITS-1:0] start_value;
  logic signed [VALUE_BITS-1:0] end_value;
  logic [TIME_BITS-1:0]         cycle_length;
  logic [MODE_BITS-1:0]         waveform_mode;

  logic [TIME_BITS-1:0]         phase_time;
  logic                         direction_up;
  logic signed [VALUE_BITS-1:0] current_level;

  logic [TIME_BITS-1:0]         t_hold;
  logic                         hit;
  logic [TIME_BITS:0]           rem;
  logic [Q_BITS-1:0]            quot;
  logic [Q_BITS-1:0]            rom_q;
  logic                         rom_neg;
  logic signed [PW-1:0]         product;

  logic [Q_BITS-1:0]            sine_rom [SINE_ENTRIES+1];

  logic [TIME_BITS-1:0]         cyc;
  logic [TIME_BITS:0]           t_sum;
  logic                         clamp;
  logic                         rem_ge;
  logic [TIME_BITS:0]           rem_sub;
  logic [PB-1:0]                pos;
  logic [PB-1:0]                pos_adj;
  logic [1:0]                   quad;
  logic [IW-1:0]                rom_idx;
  logic [Q_BITS:0]              wave_sum;
  logic [Q_BITS-1:0]            mult_m;
  logic signed [SW-1:0]         step;
  logic signed [PW-1:0]         rounded;
  logic signed [PW-1:0]         term_full;
  logic signed [SW-1:0]         term;
  logic signed [LW-1:0]         lvl_up;
  logic signed [LW-1:0]         lvl_dn;
  logic signed [VALUE_BITS-1:0] level_sel;

  for (genvar i = 0; i <= SINE_ENTRIES; i++) begin : g_rom
    assign sine_rom[i] = rom_entry(i, AB);
  end

  assign cyc     = (cycle_length == '0) ? TIME_BITS'(1) : cycle_length;
  assign t_sum   = {1'b0, phase_time} + {1'b0, elapsed_ticks};
  assign clamp   = t_sum >= {1'b0, cyc};

  assign rem_ge  = rem >= {1'b0, cyc};
  assign rem_sub = rem_ge ? rem - {1'b0, cyc} : rem;

  assign pos     = quot[FRAC_BITS-1:FRAC_BITS-PB];
  assign pos_adj = (waveform_mode == MODE_COSINE) ? pos + PB'(SINE_ENTRIES) : pos;
  assign quad    = pos_adj[PB-1:PB-2];
  assign rom_idx = quad[0] ? N_IDX - {1'b0, pos_adj[AB-1:0]} : {1'b0, pos_adj[AB-1:0]};

  assign wave_sum = rom_neg ? (Q_BITS+1)'(ONE_Q16) - {1'b0, rom_q}
                            : (Q_BITS+1)'(ONE_Q16) + {1'b0, rom_q};
  assign mult_m   = (waveform_mode == MODE_SINE || waveform_mode == MODE_COSINE)
                    ? wave_sum[Q_BITS:1] : quot;

  assign step      = {end_value[VALUE_BITS-1], end_value}
                   - {start_value[VALUE_BITS-1], start_value};
  assign rounded   = product + PW'(ROUND_HALF);
  assign term_full = rounded >>> FRAC_BITS;
  assign term      = $signed(term_full[SW-1:0]);
  assign lvl_up    = LW'(start_value) + LW'(term);
  assign lvl_dn    = LW'(end_value) - LW'(term);

  always_comb begin
    level_sel = current_level;
    case (waveform_mode) inside
      MODE_TRIANGLE: level_sel = direction_up ? lvl_up[VALUE_BITS-1:0] : lvl_dn[VALUE_BITS-1:0];
      MODE_SINE, MODE_COSINE, MODE_SAWTOOTH: level_sel = lvl_up[VALUE_BITS-1:0];
      MODE_SQUARE: level_sel = direction_up ? start_value : end_value;
      default: level_sel = current_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value   <= '0;
      end_value     <= '0;
      cycle_length  <= '0;
      waveform_mode <= MODE_TRIANGLE;
      enable        <= 1'b0;
      phase_time    <= '0;
      direction_up  <= 1'b1;
      current_level <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START: begin
          start_value   <= cfg_data[VALUE_BITS-1:0];
          phase_time    <= '0;
          direction_up  <= 1'b1;
          current_level <= cfg_data[VALUE_BITS-1:0];
        end
        REG_END: begin
          end_value     <= cfg_data[VALUE_BITS-1:0];
          phase_time    <= '0;
          direction_up  <= 1'b1;
          current_level <= start_value;
        end
        REG_CYCLE: begin
          cycle_length  <= cfg_data[TIME_BITS-1:0];
          phase_time    <= '0;
          direction_up  <= 1'b1;
          current_level <= start_value;
        end
        REG_MODE:   waveform_mode <= cfg_data[MODE_BITS-1:0];
        REG_ENABLE: enable <= cfg_data[0];
        default: ;
      endcase
    end else if (cmd.commit && enable) begin
      current_level <= level_sel;
      if (hit) begin
        phase_time   <= '0;
        direction_up <= !direction_up;
      end else begin
        phase_time <= t_hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_hold <= clamp ? cyc : t_sum[TIME_BITS-1:0];
      hit    <= clamp;
      rem    <= clamp ? {1'b0, cyc} : t_sum;
      quot   <= '0;
    end
    if (cmd.div_step) begin
      rem  <= {rem_sub[TIME_BITS-1:0], 1'b0};
      quot <= {quot[Q_BITS-2:0], rem_ge};
    end
    if (cmd.rom_read) begin
      rom_q   <= sine_rom[rom_idx];
      rom_neg <= quad[1];
    end
    if (cmd.mul) begin
      product <= step * $signed({1'b0, mult_m});
    end
    if (cmd.commit) begin
      level   <= enable ? level_sel : current_level;
      rising  <= (enable && hit) ? !direction_up : direction_up;
      wrapped <= enable && hit;
    end
  end

endmodule

`default_nettype wire

// ===== src/waveform_cycler.sv =====
// Multi-waveform low-frequency oscillator.
// The ticks channel carries the time elapsed since the previous update. Each
// accepted request yields exactly one result on the wave channel: the level,
// the direction flag after the update and a flag that marks a completed cycle.
// The mode selects triangle, sine, cosine, sawtooth or square shaping between
// the start and end values; sine and cosine come from a quarter-wave table.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// Writing the start, end or cycle length restarts the cycle at start.
// While enabled, an accepted request passes in order through the bit-serial
// restoring divider that forms the phase fraction, the table read, the
// multiply and the final add. While disabled, it goes straight to the output
// stage. The block takes no new request until the last one is committed.
// The result sits in an output register. When the receiver stalls, the block
// still accepts and works on the next request and holds it at the end until
// the output register is free. Synchronous reset clears the config registers,
// sets the level to zero and the direction to rising, and empties the output.
`default_nettype none

module waveform_cycler import wfc_pkg::*; #(
  parameter int VALUE_BITS   = DEF_VALUE_BITS,
  parameter int TIME_BITS    = DEF_TIME_BITS,
  parameter int SINE_ENTRIES = DEF_SINE_ENTRIES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [REG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS)-1:0] cfg_data,
  wfc_ticks_if.sink                      ticks,
  wfc_wave_if.source                     wave
);

  wfc_cmd_t cmd;
  logic     enable;

  wfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ticks.valid),
    .in_ready  (ticks.ready),
    .out_valid (wave.valid),
    .out_ready (wave.ready),
    .enable    (enable),
    .cmd       (cmd)
  );

  wfc_datapath #(
    .VALUE_BITS   (VALUE_BITS),
    .TIME_BITS    (TIME_BITS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .elapsed_ticks (ticks.elapsed_ticks),
    .enable        (enable),
    .level         (wave.level),
    .rising        (wave.rising),
    .wrapped       (wave.wrapped)
  );

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!wave.valid || wave.ready))
    else $error("Result written over one not yet taken.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(wave.valid) |-> $past(cmd.commit))
    else $error("Result appeared without a commit.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> $past(cmd.rom_read))
    else $error("Multiply did not follow the table read.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !ticks.ready)
    else $error("Request taken while the previous one is still in work.");

endmodule

`default_nettype wire
